@@ rtl/core/ugnq_pkg.sv @@
package ugnq_pkg;

  localparam int unsigned MaxColumns   = 32;
  localparam int unsigned MaxRows      = 32;
  localparam int unsigned CellCapacity = 16;
  localparam int unsigned MaxFound     = 64;

  localparam int unsigned ColW   = $clog2(MaxColumns);
  localparam int unsigned RowW   = $clog2(MaxRows);
  localparam int unsigned SlotW  = $clog2(CellCapacity);
  localparam int unsigned CellW  = ColW + RowW;
  localparam int unsigned NumCells = MaxColumns * MaxRows;
  localparam int unsigned EntW   = CellW + SlotW;
  localparam int unsigned FoundW = $clog2(MaxFound + 1);

  // Dividend width: point plus radius plus cell size, signed.
  localparam int unsigned NumW = 28;
  localparam int unsigned MagW = NumW - 1;

  localparam logic [1:0] FuncClear  = 2'd0;
  localparam logic [1:0] FuncInsert = 2'd1;
  localparam logic [1:0] FuncQuery  = 2'd2;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatOut   = 2'd2;
  localparam logic [1:0] StatTrunc = 2'd3;

  localparam logic [1:0] CfgCellSize = 2'd0;
  localparam logic [1:0] CfgColumns  = 2'd1;
  localparam logic [1:0] CfgRows     = 2'd2;
  localparam logic [1:0] CfgCapacity = 2'd3;

endpackage

@@ rtl/core/uniform_grid_neighbor_query.sv @@
// Channel   | Direction | Signals                                     | Handshake
// request   | in        | func_i pos_x_i pos_y_i entity_tag_i         | start_i & !busy_o
//           |           | search_radius_i shift_x_i shift_y_i         |
// result    | out       | status_o found_o found_x_o found_y_o        | done_o, one cycle
//           |           | found_tag_o last_o                          |
// config    | in        | cfg_index_i cfg_data_i                      | cfg_valid_i & cfg_ready_o
//
// Every insert or query first runs four divisions through one shared restoring
// divider, each a load state and 27 steps, before the body. An insert then reads
// its cell count in S_IRD and checks and updates the cell in S_ICHK. A query
// reads each visited cell's count through S_CREAD, S_CCHK and S_EREAD, fetches
// each returned entity through S_EREAD and S_EGET, and sends the final result from S_FLUSH.
// A clear sweeps the 1024-entry count memory, one entry a cycle; the same
// sweep runs after reset before the first request is taken.
// Results cannot be stalled; each shows for one cycle under done_o.
module uniform_grid_neighbor_query (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [23:0] pos_x_i,
  input  logic [23:0] pos_y_i,
  input  logic [31:0] entity_tag_i,
  input  logic [22:0] search_radius_i,
  input  logic [23:0] shift_x_i,
  input  logic [23:0] shift_y_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [23:0] found_x_o,
  output logic [23:0] found_y_o,
  output logic [31:0] found_tag_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [22:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV_LD, S_DIV_RUN, S_DISPATCH, S_IRD, S_ICHK,
    S_CREAD, S_CCHK, S_EREAD, S_EGET, S_FLUSH
  } state_e;

  localparam int unsigned NW = ugnq_pkg::NumW;
  localparam int unsigned MW = ugnq_pkg::MagW;

  state_e state_q;

  logic [22:0] cell_size_q;
  logic [5:0]  columns_q, rows_q;
  logic [4:0]  capacity_q;

  logic [1:0]  func_q;
  logic signed [NW-1:0] px_q, py_q, r_q;
  logic [23:0] in_x_q, in_y_q;
  logic [31:0] in_tag_q;

  logic [1:0]        sel_q;
  logic [MW-1:0]     num_q;
  logic [22:0]       rem_q;
  logic              neg_q;
  logic [4:0]        step_q;
  logic signed [NW-1:0] quo_q [4];

  logic [ugnq_pkg::CellW-1:0] clr_addr_q;
  logic                       clr_emit_q;

  logic [ugnq_pkg::CellW-1:0] cell_q;
  logic [5:0] col_q, row_q, rx_q, ly_q, ry_q;
  logic [4:0] cnt_q, k_q;
  logic [ugnq_pkg::FoundW-1:0] n_q;
  logic        pend_v_q, trunc_q;
  logic [79:0] pend_q;

  logic [4:0]  cnt_mem [ugnq_pkg::NumCells];
  logic [79:0] ent_mem [ugnq_pkg::NumCells * ugnq_pkg::CellCapacity];
  logic [4:0]  cnt_rd_q;
  logic [79:0] ent_rd_q;

  // Effective register values.
  logic [22:0] gs;
  logic [5:0]  cols, rows;
  logic [4:0]  cap;
  assign gs   = (cell_size_q == 23'd0) ? 23'd1 : cell_size_q;
  assign cols = (columns_q == 6'd0) ? 6'd1 :
                (columns_q > 6'(ugnq_pkg::MaxColumns)) ? 6'(ugnq_pkg::MaxColumns) : columns_q;
  assign rows = (rows_q == 6'd0) ? 6'd1 :
                (rows_q > 6'(ugnq_pkg::MaxRows)) ? 6'(ugnq_pkg::MaxRows) : rows_q;
  assign cap  = (capacity_q == 5'd0) ? 5'd1 :
                (capacity_q > 5'(ugnq_pkg::CellCapacity)) ?
                5'(ugnq_pkg::CellCapacity) : capacity_q;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Dividend for the current division: left and right bounds of x, then y.
  logic signed [NW-1:0] gs_s, dvd;
  logic [MW-1:0] dvd_mag;
  assign gs_s = $signed({{(NW-23){1'b0}}, gs});
  always_comb begin
    case (sel_q)
      2'd0:    dvd = px_q - r_q;
      2'd1:    dvd = px_q + r_q + gs_s;
      2'd2:    dvd = py_q - r_q;
      default: dvd = py_q + r_q + gs_s;
    endcase
  end
  assign dvd_mag = dvd[NW-1] ? MW'(-dvd) : dvd[MW-1:0];

  logic [23:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q, num_q[MW-1]};
  assign rem_ge = (rem_sh >= {1'b0, gs});

  logic signed [NW-1:0] quo_fin, cols_s, rows_s;
  assign quo_fin = neg_q ? -$signed({1'b0, num_q[MW-2:0], rem_ge})
                         :  $signed({1'b0, num_q[MW-2:0], rem_ge});
  assign cols_s = $signed({{(NW-6){1'b0}}, cols});
  assign rows_s = $signed({{(NW-6){1'b0}}, rows});

  function automatic logic [5:0] clamp_idx(logic signed [NW-1:0] v,
                                           logic signed [NW-1:0] hi);
    logic [5:0] res;
    if (v < 0) res = 6'd0;
    else if (v > hi) res = hi[5:0];
    else res = v[5:0];
    return res;
  endfunction

  logic [5:0] lx_c, rx_c, ly_c, ry_c;
  assign lx_c = clamp_idx(quo_q[0], cols_s);
  assign rx_c = clamp_idx(quo_q[1], cols_s);
  assign ly_c = clamp_idx(quo_q[2], rows_s);
  assign ry_c = clamp_idx(quo_q[3], rows_s);

  logic ins_out;
  assign ins_out = (quo_q[0] < 0) || (quo_q[0] >= cols_s) ||
                   (quo_q[2] < 0) || (quo_q[2] >= rows_s);

  // Memory ports, driven from the current state.
  logic                       cnt_we, ent_we;
  logic [ugnq_pkg::CellW-1:0] cnt_waddr, cnt_raddr;
  logic [4:0]                 cnt_wdata;
  logic [ugnq_pkg::EntW-1:0]  ent_addr;
  logic                       ent_re;
  logic                       cell_full;
  assign cell_full = (cnt_rd_q >= cap);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = cell_q;
    cnt_wdata = cnt_rd_q + 5'd1;
    cnt_raddr = {row_q[ugnq_pkg::RowW-1:0], col_q[ugnq_pkg::ColW-1:0]};
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    ent_addr  = {cell_q, k_q[ugnq_pkg::SlotW-1:0]};
    case (state_q)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr_q;
        cnt_wdata = 5'd0;
      end
      S_IRD: cnt_raddr = cell_q;
      S_ICHK: begin
        cnt_we   = !cell_full;
        ent_we   = !cell_full;
        ent_addr = {cell_q, cnt_rd_q[ugnq_pkg::SlotW-1:0]};
      end
      S_EREAD: ent_re = (k_q < cnt_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_addr] <= {in_tag_q, in_y_q, in_x_q};
    if (ent_re) ent_rd_q <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cell_size_q <= 23'd256;
      columns_q   <= 6'd32;
      rows_q      <= 6'd32;
      capacity_q  <= 5'd10;
      clr_addr_q  <= '0;
      clr_emit_q  <= 1'b0;
      done_o      <= 1'b0;
      sel_q       <= '0;
      step_q      <= '0;
      pend_v_q    <= 1'b0;
      trunc_q     <= 1'b0;
      n_q         <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ugnq_pkg::CfgCellSize: cell_size_q <= cfg_data_i;
          ugnq_pkg::CfgColumns:  columns_q   <= cfg_data_i[5:0];
          ugnq_pkg::CfgRows:     rows_q      <= cfg_data_i[5:0];
          ugnq_pkg::CfgCapacity: capacity_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      case (state_q)
        S_CLR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == ugnq_pkg::CellW'(ugnq_pkg::NumCells - 1)) begin
            state_q <= S_IDLE;
            if (clr_emit_q) begin
              done_o      <= 1'b1;
              status_o    <= ugnq_pkg::StatOk;
              found_o     <= 1'b0;
              found_x_o   <= '0;
              found_y_o   <= '0;
              found_tag_o <= '0;
              last_o      <= 1'b1;
            end
          end
        end
        S_IDLE: begin
          if (start_i) begin
            func_q   <= func_i;
            in_x_q   <= pos_x_i;
            in_y_q   <= pos_y_i;
            in_tag_q <= entity_tag_i;
            sel_q    <= '0;
            if (func_i == ugnq_pkg::FuncClear) begin
              clr_addr_q <= '0;
              clr_emit_q <= 1'b1;
              state_q    <= S_CLR;
            end else if (func_i == ugnq_pkg::FuncInsert) begin
              px_q    <= NW'($signed(pos_x_i));
              py_q    <= NW'($signed(pos_y_i));
              r_q     <= '0;
              state_q <= S_DIV_LD;
            end else if (func_i == ugnq_pkg::FuncQuery) begin
              px_q    <= NW'($signed(pos_x_i)) + NW'($signed(shift_x_i));
              py_q    <= NW'($signed(pos_y_i)) + NW'($signed(shift_y_i));
              r_q     <= $signed({{(NW-23){1'b0}}, search_radius_i});
              state_q <= S_DIV_LD;
            end
          end
        end
        S_DIV_LD: begin
          num_q   <= dvd_mag;
          neg_q   <= dvd[NW-1];
          rem_q   <= '0;
          step_q  <= 5'(MW - 1);
          state_q <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          rem_q  <= rem_ge ? 23'(rem_sh - {1'b0, gs}) : rem_sh[22:0];
          num_q  <= {num_q[MW-2:0], rem_ge};
          step_q <= step_q - 5'd1;
          if (step_q == 5'd0) begin
            quo_q[sel_q] <= quo_fin;
            sel_q        <= sel_q + 2'd1;
            state_q      <= (sel_q == 2'd3) ? S_DISPATCH : S_DIV_LD;
          end
        end
        S_DISPATCH: begin
          if (func_q == ugnq_pkg::FuncInsert) begin
            cell_q <= {quo_q[2][ugnq_pkg::RowW-1:0], quo_q[0][ugnq_pkg::ColW-1:0]};
            if (ins_out) begin
              done_o      <= 1'b1;
              status_o    <= ugnq_pkg::StatOut;
              found_o     <= 1'b0;
              found_x_o   <= '0;
              found_y_o   <= '0;
              found_tag_o <= '0;
              last_o      <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_IRD;
            end
          end else begin
            rx_q     <= rx_c;
            ly_q     <= ly_c;
            ry_q     <= ry_c;
            col_q    <= lx_c;
            row_q    <= ly_c;
            n_q      <= '0;
            pend_v_q <= 1'b0;
            trunc_q  <= 1'b0;
            state_q  <= ((lx_c >= rx_c) || (ly_c >= ry_c)) ? S_FLUSH : S_CREAD;
          end
        end
        S_IRD: state_q <= S_ICHK;
        S_ICHK: begin
          done_o      <= 1'b1;
          status_o    <= cell_full ? ugnq_pkg::StatFull : ugnq_pkg::StatOk;
          found_o     <= 1'b0;
          found_x_o   <= '0;
          found_y_o   <= '0;
          found_tag_o <= '0;
          last_o      <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_CREAD: begin
          cell_q  <= cnt_raddr;
          state_q <= S_CCHK;
        end
        S_CCHK: begin
          cnt_q   <= (cnt_rd_q > 5'(ugnq_pkg::CellCapacity)) ?
                     5'(ugnq_pkg::CellCapacity) : cnt_rd_q;
          k_q     <= '0;
          state_q <= S_EREAD;
        end
        S_EREAD: begin
          if (k_q < cnt_q) begin
            if (n_q == ugnq_pkg::FoundW'(ugnq_pkg::MaxFound)) begin
              trunc_q <= 1'b1;
              state_q <= S_FLUSH;
            end else begin
              k_q     <= k_q + 5'd1;
              state_q <= S_EGET;
            end
          end else if (row_q + 6'd1 < ry_q) begin
            row_q   <= row_q + 6'd1;
            state_q <= S_CREAD;
          end else if (col_q + 6'd1 < rx_q) begin
            row_q   <= ly_q;
            col_q   <= col_q + 6'd1;
            state_q <= S_CREAD;
          end else begin
            state_q <= S_FLUSH;
          end
        end
        S_EGET: begin
          // The previous entity is sent once a later one is known to exist.
          if (pend_v_q) begin
            done_o      <= 1'b1;
            status_o    <= ugnq_pkg::StatOk;
            found_o     <= 1'b1;
            found_x_o   <= pend_q[23:0];
            found_y_o   <= pend_q[47:24];
            found_tag_o <= pend_q[79:48];
            last_o      <= 1'b0;
          end
          pend_q   <= ent_rd_q;
          pend_v_q <= 1'b1;
          n_q      <= n_q + 1'b1;
          state_q  <= S_EREAD;
        end
        S_FLUSH: begin
          done_o      <= 1'b1;
          last_o      <= 1'b1;
          found_o     <= pend_v_q;
          status_o    <= trunc_q ? ugnq_pkg::StatTrunc : ugnq_pkg::StatOk;
          found_x_o   <= pend_v_q ? pend_q[23:0]  : 24'd0;
          found_y_o   <= pend_v_q ? pend_q[47:24] : 24'd0;
          found_tag_o <= pend_v_q ? pend_q[79:48] : 32'd0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
